### src/idlr_pkg.sv
package idlr_pkg;

  localparam logic [7:0] CMD_POLL  = 8'h74;
  localparam logic [7:0] CMD_POWER = 8'h70;
  localparam logic [7:0] CMD_QUERY = 8'h76;

  localparam logic [2:0] LEN_QUERY = 3'd2;
  localparam logic [2:0] LEN_OTHER = 3'd4;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;

  typedef enum logic [1:0] {
    RESP_RESET = 2'd0,
    RESP_DFU   = 2'd1,
    RESP_POWER = 2'd2,
    RESP_QUERY = 2'd3
  } resp_t;

  typedef struct packed {
    logic take_in;
    logic take_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reply;
    logic last;
  } dp_status_t;

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  // index of the crc byte, equal to the payload length
  function automatic logic [3:0] resp_last(input resp_t resp);
    logic [3:0] n;
    unique case (resp)
      RESP_RESET: n = 4'd7;
      RESP_DFU:   n = 4'd7;
      RESP_POWER: n = 4'd2;
      RESP_QUERY: n = 4'd12;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] resp_byte(input resp_t resp, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (resp)
      RESP_RESET: begin
        case (idx)
          4'd0:    b = 8'h75;
          4'd1:    b = 8'hC0;
          default: b = 8'h00;
        endcase
      end
      RESP_DFU: begin
        case (idx)
          4'd0:    b = 8'h75;
          4'd1:    b = 8'h20;
          4'd3:    b = 8'h02;
          default: b = 8'h00;
        endcase
      end
      RESP_POWER: begin
        case (idx)
          4'd0:    b = 8'h71;
          4'd1:    b = 8'h93;
          default: b = 8'h00;
        endcase
      end
      RESP_QUERY: begin
        case (idx)
          4'd0:    b = 8'h77;
          4'd1:    b = 8'h02;
          4'd2:    b = 8'h01;
          4'd3:    b = 8'h02;
          4'd4:    b = 8'h80;
          4'd5:    b = 8'h60;
          4'd6:    b = 8'h01;
          4'd7:    b = 8'h39;
          4'd8:    b = 8'h3A;
          4'd9:    b = 8'h44;
          4'd10:   b = 8'h3E;
          4'd11:   b = 8'hC9;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### src/idlr_ctrl.sv
module idlr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  idlr_pkg::dp_status_t   status,
  output idlr_pkg::ctrl_cmd_t    cmd
);
  import idlr_pkg::*;

  typedef enum logic [1:0] {
    ST_RECV = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready     = (state == ST_RECV);
  assign out_valid    = (state == ST_SEND);
  assign cmd.take_in  = in_valid & in_ready;
  assign cmd.take_out = out_valid & out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: begin
        if (cmd.take_in && status.reply) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (cmd.take_out && status.last) begin
          state_next = ST_RECV;
        end
      end
      default: state_next = ST_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/idlr_datapath.sv
module idlr_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  idlr_pkg::ctrl_cmd_t    cmd,
  input  logic [7:0]             rx_byte,
  output idlr_pkg::dp_status_t   status,
  output logic [7:0]             tx_byte,
  output logic                   last_byte,
  output logic                   transition_on,
  output logic                   dfu_sent
);
  import idlr_pkg::*;

  logic [7:0] command_code;
  logic [2:0] bytes_held;
  logic [1:0] poll_phase;
  logic       transition_flag;
  logic       dfu_flag;
  resp_t      resp;
  logic [3:0] idx;
  logic [7:0] crc;

  logic [7:0] v;
  logic [2:0] held_inc;
  logic       is_cmd;
  logic       done;
  logic       poll_live;

  assign v         = bit_rev(rx_byte);
  assign held_inc  = bytes_held + 3'd1;
  assign is_cmd    = (v == CMD_POLL) || (v == CMD_POWER) || (v == CMD_QUERY);
  assign done      = (bytes_held != 3'd0) &&
                     (((command_code == CMD_QUERY) && (held_inc == LEN_QUERY)) ||
                      (((command_code == CMD_POLL) || (command_code == CMD_POWER)) &&
                       (held_inc == LEN_OTHER)));
  assign poll_live = (poll_phase == PHASE_FIRST) || (poll_phase == PHASE_SECOND);

  assign status.reply = done && ((command_code == CMD_POWER) ||
                                 (command_code == CMD_QUERY) ||
                                 ((command_code == CMD_POLL) && poll_live));
  assign status.last  = (idx == resp_last(resp));

  assign tx_byte       = status.last ? crc : resp_byte(resp, idx);
  assign last_byte     = status.last;
  assign transition_on = transition_flag;
  assign dfu_sent      = dfu_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_code    <= 8'h00;
      bytes_held      <= 3'd0;
      poll_phase      <= PHASE_FIRST;
      transition_flag <= 1'b0;
      dfu_flag        <= 1'b0;
    end else if (cmd.take_in) begin
      if (bytes_held == 3'd0) begin
        if (is_cmd) begin
          command_code <= v;
          bytes_held   <= 3'd1;
        end
      end else if (done) begin
        bytes_held <= 3'd0;
        if (command_code == CMD_POLL) begin
          if (poll_phase == PHASE_FIRST) begin
            transition_flag <= 1'b1;
            poll_phase      <= PHASE_SECOND;
          end else if (poll_phase == PHASE_SECOND) begin
            transition_flag <= 1'b0;
            dfu_flag        <= 1'b1;
            poll_phase      <= PHASE_DONE;
          end
        end
      end else begin
        bytes_held <= held_inc;
      end
    end
  end

  // response sequencing: byte index, running crc and response select
  always_ff @(posedge clk) begin
    if (cmd.take_in && status.reply) begin
      idx <= 4'd0;
      crc <= CRC_INIT;
      if (command_code == CMD_POWER) begin
        resp <= RESP_POWER;
      end else if (command_code == CMD_QUERY) begin
        resp <= RESP_QUERY;
      end else if (poll_phase == PHASE_FIRST) begin
        resp <= RESP_RESET;
      end else begin
        resp <= RESP_DFU;
      end
    end else if (cmd.take_out) begin
      idx <= idx + 4'd1;
      crc <= crc_step(crc, tx_byte);
    end
  end

endmodule

### src/id_line_request_responder_core.sv
// channel   signals                                            direction
// input     in_valid, in_ready, rx_byte                        into block
// output    out_valid, out_ready, tx_byte, last_byte,          out of block
//           transition_on, dfu_sent
//
// one received byte is taken per cycle while no response is pending
// a completed request with a reply blocks input until its n+1 bytes are sent,
// one per cycle with out_ready high: 3, 8 or 13 bytes, set by the byte sequencer
// crc is built one byte per cycle as each byte leaves
// synchronous active-high reset returns to idle, awaiting the first poll
// out_ready low holds the current byte and its flags unchanged
module id_line_request_responder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       last_byte,
  output logic       transition_on,
  output logic       dfu_sent
);
  import idlr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  idlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  idlr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .status        (status),
    .tx_byte       (tx_byte),
    .last_byte     (last_byte),
    .transition_on (transition_on),
    .dfu_sent      (dfu_sent)
  );

endmodule
